>>> rtl/cdq_pkg.sv
// Package for the circular deque: sizes, operation codes and the cell control bundle.
// No dependencies; every other file of the block imports it.
package cdq_pkg;

    localparam int DEPTH  = 16;   // number of cells in the row
    localparam int DATA_W = 32;   // width of one stored value
    localparam int CAP_W  = 5;    // width of capacity and occupancy (holds DEPTH itself)

    // Operation carried by an input item
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    // What every cell does at the next edge
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN,    // take the left neighbor's contents (push front)
        OP_SHIFT_OUT,   // take the right neighbor's contents (pop front)
        OP_APPEND,      // first empty cell takes the new value (push back)
        OP_TRIM         // last full cell drops its value (pop back)
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

>>> rtl/cdq_if.sv
// Handshake channels of the circular deque: input items, result items, capacity writes.
// Depends on cdq_pkg.
interface cdq_in_if
    import cdq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cdq_out_if
    import cdq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  rear_value;
    logic [CAP_W-1:0]          occupancy;
    logic                      is_empty;
    logic                      is_full;

    modport source (output valid, output accepted, output front_value, output rear_value,
                    output occupancy, output is_empty, output is_full, input ready);
    modport sink   (input valid, input accepted, input front_value, input rear_value,
                    input occupancy, input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if
    import cdq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CAP_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/cdq_cell.sv
// One cell of the deque row: a stored value, its valid bit and the neighbor hand-off.
// Depends on cdq_pkg.
module cdq_cell
    import cdq_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cell_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0]  left_data,
    input  logic                      left_valid,
    input  logic signed [DATA_W-1:0]  right_data,
    input  logic                      right_valid,
    output logic signed [DATA_W-1:0]  data,
    output logic                      valid,
    output logic                      tail
);

    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                     valid_reg, valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctrl.op)
            OP_SHIFT_IN:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            OP_SHIFT_OUT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            OP_APPEND:
            begin
                // only the first empty cell sees a full left neighbor
                if (!valid_reg && left_valid)
                begin
                    data_next  = ctrl.value;
                    valid_next = 1'b1;
                end
            end
            OP_TRIM:
            begin
                if (valid_reg && !right_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tail  = valid_reg && !right_valid;

endmodule

>>> rtl/circular_deque.sv
// Top level of the circular deque: control, capacity register and the row of cells.
// Depends on cdq_pkg, cdq_if (channels) and cdq_cell.
//
//  channel   modport  carries                                             accepted when
//  --------  -------  --------------------------------------------------  ---------------
//  in_ch     sink     kind, value                                         valid && ready
//  out_ch    source   accepted, front_value, rear_value, occupancy,       valid && ready
//                     is_empty, is_full
//  cfg       sink     data (capacity)                                     valid && ready
//
// One item per cycle: an accepted item updates the cell row at the same edge, and its
// result shows on out_ch from the next cycle on, read straight from the row and the count.
// A new item is taken while the pending result is being taken, so the rate is set by the
// output side; a stalled result holds in_ch.ready low and freezes the row.
// Reset empties every cell (valid bits cleared) and sets capacity to DEPTH; stored values
// are not cleared. Capacity writes are always ready and take effect only while empty.
module circular_deque
    import cdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cdq_in_if.sink     in_ch,
    cdq_out_if.source  out_ch,
    cdq_cfg_if.sink    cfg
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic [CAP_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             accepted_reg, accepted_next;

    logic             in_accept;
    logic             is_push;
    logic             op_ok;
    kind_t            kind;
    cell_ctrl_t       ctrl;

    logic signed [DATA_W-1:0] cell_data  [DEPTH];
    logic                     cell_valid [DEPTH];
    logic                     cell_tail  [DEPTH];
    logic signed [DATA_W-1:0] rear_sel;

    // take a new item once the pending result is gone or leaves this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign kind        = kind_t'(in_ch.kind);
    assign is_push     = (kind == KIND_PUSH_FRONT) || (kind == KIND_PUSH_BACK);
    // refuse a push when full and a pop when empty
    assign op_ok       = is_push ? (count_reg < capacity_reg) : (count_reg != '0);

    always_comb
    begin
        ctrl.value = in_ch.value;
        ctrl.op    = OP_HOLD;
        if (in_accept && op_ok)
        begin
            unique case (kind)
                KIND_PUSH_FRONT: ctrl.op = OP_SHIFT_IN;
                KIND_PUSH_BACK:  ctrl.op = OP_APPEND;
                KIND_POP_FRONT:  ctrl.op = OP_SHIFT_OUT;
                KIND_POP_BACK:   ctrl.op = OP_TRIM;
                default:         ctrl.op = OP_HOLD;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_accept && op_ok)
        begin
            count_next = is_push ? count_reg + 1'b1 : count_reg - 1'b1;
        end
    end

    // clamp the written capacity to 1..DEPTH; ignore it unless the deque is empty
    always_comb
    begin
        capacity_next = capacity_reg;
        if (cfg.valid && cfg.ready && (count_reg == '0))
        begin
            if (cfg.data == '0)
            begin
                capacity_next = CAP_W'(1);
            end
            else if (cfg.data > CAP_W'(DEPTH))
            begin
                capacity_next = CAP_W'(DEPTH);
            end
            else
            begin
                capacity_next = cfg.data;
            end
        end
    end
    assign cfg.ready = 1'b1;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        accepted_next  = accepted_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            accepted_next  = op_ok;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_W'(DEPTH);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            accepted_reg  <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            accepted_reg  <= accepted_next;
        end
    end

    // Row of cells: cell 0 holds the front, the last valid cell holds the rear.
    // The new value enters cell 0 from the left as an always-valid neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] l_data, r_data;
        logic                     l_valid, r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = in_ch.value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH-1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        cdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .tail        (cell_tail[i])
        );
    end

    // pick the rear value from the one cell flagged as tail (none when empty)
    always_comb
    begin
        rear_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_sel = rear_sel | (cell_tail[i] ? cell_data[i] : '0);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.accepted    = accepted_reg;
    assign out_ch.front_value = cell_valid[0] ? cell_data[0] : '0;
    assign out_ch.rear_value  = rear_sel;
    assign out_ch.occupancy   = count_reg;
    assign out_ch.is_empty    = (count_reg == '0);
    assign out_ch.is_full     = (count_reg == capacity_reg);

endmodule
